// ===== src/mrrpm_pkg.sv =====
// shared types, codes and offset arithmetic for the ring pointer manager
package mrrpm_pkg;

    // largest ring and number of consumer slots the block can address
    localparam int SIZE_LIMIT = 65536;
    localparam int SLOT_LIMIT = 8;

    // action codes of an input item
    typedef enum logic [3:0] {
        ACT_ATTACH_PROD = 4'd0,
        ACT_ATTACH_CONS = 4'd1,
        ACT_REL_PROD    = 4'd2,
        ACT_REL_CONS    = 4'd3,
        ACT_PUT         = 4'd4,
        ACT_GET         = 4'd5,
        ACT_PEEK        = 4'd6,
        ACT_SKIP        = 4'd7,
        ACT_USAGE       = 4'd8
    } action_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BUSY     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_BLOCK    = 3'd3,
        ST_DETACHED = 3'd4
    } status_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_RING_SIZE = 2'd0,
        REG_RING_BASE = 2'd1,
        REG_CONS_CNT  = 2'd2
    } reg_idx_t;

    // controller sequencing
    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_PRE,
        FSM_EXEC,
        FSM_POST,
        FSM_DONE
    } fsm_t;

    // operation broadcast to the consumer cells
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ATTACH,
        CELL_RELEASE,
        CELL_LOAD,
        CELL_REWIND
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [2:0]  slot;
        logic [15:0] offset;
    } cell_cmd_t;

    // running backlog summary handed from cell to cell
    typedef struct packed {
        logic        any;
        logic [15:0] hi;
        logic [15:0] lo;
    } scan_t;

    // configuration values in use
    typedef struct packed {
        logic [16:0] size;
        logic [31:0] base;
        logic [3:0]  count;
        logic        rewind;
        logic        wr;
    } cfg_t;

    // bytes a consumer at off still has to read
    function automatic logic [15:0] backlog(input logic [15:0] prod,
                                            input logic [15:0] off,
                                            input logic [16:0] size);
        logic [16:0] d;
        if (prod >= off)
            d = {1'b0, prod} - {1'b0, off};
        else
            d = size - {1'b0, off} + {1'b0, prod};
        return d[15:0];
    endfunction

    // offset moved forward by len, wrapped at the ring size
    function automatic logic [15:0] advance(input logic [15:0] off,
                                            input logic [16:0] len,
                                            input logic [16:0] size);
        logic [17:0] n;
        n = {2'b00, off} + {1'b0, len};
        if (n >= {1'b0, size})
            n = n - {1'b0, size};
        return n[15:0];
    endfunction

endpackage

// ===== src/multi_reader_ring_pointer_manager.sv =====
// top level: action sequencer, producer state and the chain of consumer cells
//
// Pointer manager for a byte ring with one producer and up to eight consumers.
// Items arrive on item_valid / item_stall with action, slot, length and
// min_length; each gives exactly one result on result_valid / result_stall
// with status, slot_out, address, count and the usage summary after the action.
// The block works on one item at a time: item_stall is high from the accept
// until the controller is back in idle. Each item is executed, then the
// backlog summary ripples down the chain of consumer cells (one cell per
// cycle), and then the result register is loaded. A put that follows reset
// or a configuration write first waits for one more pass of the summary
// down the chain to learn the current space. A finished result waits in its
// output register while result_stall is high; the next item is still taken,
// and its own result is held back until the register frees up. Reset clears
// all offsets and attach bits and loads ring_size 65536, ring_base 0 and
// consumer_count 8. Writing ring_size rewinds every offset to zero.
module multi_reader_ring_pointer_manager #(
    parameter int RING_BYTES    = 65536,
    parameter int MAX_CONSUMERS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [3:0]  action,
    input  logic [2:0]  slot,
    input  logic [16:0] length,
    input  logic [16:0] min_length,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [2:0]  slot_out,
    output logic [31:0] address,
    output logic [16:0] count,
    output logic [15:0] put_space,
    output logic [15:0] min_get,
    output logic [15:0] max_get,
    output logic        producer_on
);

    localparam int SIZE_CAP = (RING_BYTES < mrrpm_pkg::SIZE_LIMIT) ?
                              RING_BYTES : mrrpm_pkg::SIZE_LIMIT;
    localparam int SLOTS    = (MAX_CONSUMERS < mrrpm_pkg::SLOT_LIMIT) ?
                              MAX_CONSUMERS : mrrpm_pkg::SLOT_LIMIT;
    localparam int CW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);

    mrrpm_pkg::cfg_t      cfg;
    mrrpm_pkg::fsm_t      state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 fresh_reg;
    logic                 out_load;
    logic                 accept;

    // captured item
    logic [3:0]           act_reg;
    logic [2:0]           slot_reg;
    logic [16:0]          len_reg;
    logic [16:0]          minl_reg;

    // producer state
    logic [15:0]          prod_off_reg, prod_off_next;
    logic                 prod_on_reg, prod_on_next;

    // pending result from the execute cycle
    mrrpm_pkg::status_t   res_status_reg, res_status_next;
    logic [2:0]           res_slot_reg, res_slot_next;
    logic [31:0]          res_addr_reg, res_addr_next;
    logic [16:0]          res_count_reg, res_count_next;

    // output register
    logic                 result_valid_reg;
    logic [2:0]           status_reg;
    logic [2:0]           slot_out_reg;
    logic [31:0]          address_reg;
    logic [16:0]          count_reg;
    logic [15:0]          put_space_reg;
    logic [15:0]          min_get_reg;
    logic [15:0]          max_get_reg;
    logic                 producer_on_reg;

    // cell chain
    mrrpm_pkg::scan_t     chain [0:SLOTS];
    logic [15:0]          cell_off [0:SLOTS-1];
    logic                 cell_act [0:SLOTS-1];
    mrrpm_pkg::cell_cmd_t cmd, ex_cmd;

    // execute-cycle helpers
    logic [15:0]          sel_off;
    logic                 sel_act;
    logic                 slot_ok;
    logic                 free_found;
    logic [2:0]           free_idx;
    logic [15:0]          sel_blog;
    logic [16:0]          get_cnt;
    logic [15:0]          hi_sum;
    logic [15:0]          space_now;
    logic [31:0]          prod_addr;
    logic [31:0]          cons_addr;

    mrrpm_cfg #(
        .SIZE_CAP (SIZE_CAP),
        .SLOTS    (SLOTS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // chain of consumer cells, summary enters empty at the head
    assign chain[0] = '{any: 1'b0, hi: 16'd0, lo: 16'hFFFF};

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        mrrpm_cell #(
            .IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .size     (cfg.size),
            .count    (cfg.count),
            .prod     (prod_off_reg),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1]),
            .offset   (cell_off[g]),
            .active   (cell_act[g])
        );
    end

    // slot lookup and first free slot
    always_comb
    begin
        sel_off    = 16'd0;
        sel_act    = 1'b0;
        free_found = 1'b0;
        free_idx   = 3'd0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_reg == 3'(i))
            begin
                sel_off = cell_off[i];
                sel_act = cell_act[i];
            end
        end
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!cell_act[i] && (4'(i) < cfg.count))
            begin
                free_found = 1'b1;
                free_idx   = 3'(i);
            end
        end
    end

    assign slot_ok   = ({1'b0, slot_reg} < cfg.count);
    assign sel_blog  = mrrpm_pkg::backlog(prod_off_reg, sel_off, cfg.size);
    assign get_cnt   = (len_reg > {1'b0, sel_blog}) ? {1'b0, sel_blog} : len_reg;
    assign hi_sum    = chain[SLOTS].any ? chain[SLOTS].hi : 16'd0;
    assign space_now = 16'(cfg.size - 17'd1 - {1'b0, hi_sum});
    assign prod_addr = cfg.base + {16'd0, prod_off_reg};
    assign cons_addr = cfg.base + {16'd0, sel_off};

    // action execution
    always_comb
    begin
        res_status_next = mrrpm_pkg::ST_OK;
        res_slot_next   = 3'd0;
        res_addr_next   = 32'd0;
        res_count_next  = 17'd0;
        prod_off_next   = prod_off_reg;
        prod_on_next    = prod_on_reg;
        ex_cmd          = '{op: mrrpm_pkg::CELL_HOLD, slot: slot_reg, offset: 16'd0};
        unique case (act_reg) inside
            mrrpm_pkg::ACT_ATTACH_PROD:
            begin
                if (prod_on_reg)
                    res_status_next = mrrpm_pkg::ST_BUSY;
                else
                    prod_on_next = 1'b1;
            end
            mrrpm_pkg::ACT_ATTACH_CONS:
            begin
                if (!free_found)
                    res_status_next = mrrpm_pkg::ST_BUSY;
                else
                begin
                    res_slot_next = free_idx;
                    res_addr_next = prod_addr;
                    ex_cmd = '{op: mrrpm_pkg::CELL_ATTACH, slot: free_idx,
                               offset: prod_off_reg};
                end
            end
            mrrpm_pkg::ACT_REL_PROD:
            begin
                if (!prod_on_reg)
                    res_status_next = mrrpm_pkg::ST_DETACHED;
                else
                    prod_on_next = 1'b0;
            end
            mrrpm_pkg::ACT_PUT:
            begin
                if (!prod_on_reg)
                    res_status_next = mrrpm_pkg::ST_DETACHED;
                else if (len_reg > cfg.size)
                    res_status_next = mrrpm_pkg::ST_RANGE;
                else if (len_reg > {1'b0, space_now})
                    res_status_next = mrrpm_pkg::ST_BLOCK;
                else
                begin
                    res_addr_next  = prod_addr;
                    res_count_next = len_reg;
                    prod_off_next  = mrrpm_pkg::advance(prod_off_reg, len_reg, cfg.size);
                end
            end
            mrrpm_pkg::ACT_REL_CONS, mrrpm_pkg::ACT_GET,
            mrrpm_pkg::ACT_PEEK, mrrpm_pkg::ACT_SKIP:
            begin
                if (!slot_ok)
                    res_status_next = mrrpm_pkg::ST_RANGE;
                else if (!sel_act)
                    res_status_next = mrrpm_pkg::ST_DETACHED;
                else if (act_reg == mrrpm_pkg::ACT_REL_CONS)
                    ex_cmd.op = mrrpm_pkg::CELL_RELEASE;
                else if (act_reg == mrrpm_pkg::ACT_SKIP)
                begin
                    if (len_reg > cfg.size)
                        res_status_next = mrrpm_pkg::ST_RANGE;
                    else
                    begin
                        res_addr_next  = cons_addr;
                        res_count_next = len_reg;
                        ex_cmd.op      = mrrpm_pkg::CELL_LOAD;
                        ex_cmd.offset  = mrrpm_pkg::advance(sel_off, len_reg, cfg.size);
                    end
                end
                else if (act_reg == mrrpm_pkg::ACT_GET)
                begin
                    if (minl_reg > cfg.size)
                        res_status_next = mrrpm_pkg::ST_RANGE;
                    else if ({1'b0, sel_blog} < minl_reg)
                        res_status_next = mrrpm_pkg::ST_BLOCK;
                    else
                    begin
                        res_addr_next  = cons_addr;
                        res_count_next = get_cnt;
                        ex_cmd.op      = mrrpm_pkg::CELL_LOAD;
                        ex_cmd.offset  = mrrpm_pkg::advance(sel_off, get_cnt, cfg.size);
                    end
                end
                else
                begin
                    res_addr_next  = cons_addr;
                    res_count_next = get_cnt;
                end
            end
            mrrpm_pkg::ACT_USAGE:
            begin
                res_status_next = mrrpm_pkg::ST_OK;
            end
            default:
            begin
                res_status_next = mrrpm_pkg::ST_RANGE;
            end
        endcase
    end

    // command to the cells: rewind on a ring_size write, else the action while executing
    always_comb
    begin
        if (cfg.rewind)
            cmd = '{op: mrrpm_pkg::CELL_REWIND, slot: 3'd0, offset: 16'd0};
        else if (state_reg == mrrpm_pkg::FSM_EXEC)
            cmd = ex_cmd;
        else
            cmd = '{op: mrrpm_pkg::CELL_HOLD, slot: 3'd0, offset: 16'd0};
    end

    // sequencer next state and handshake
    always_comb
    begin
        state_next = state_reg;
        item_stall = 1'b1;
        out_load   = 1'b0;
        unique case (state_reg)
            mrrpm_pkg::FSM_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    if ((action == mrrpm_pkg::ACT_PUT) && !fresh_reg)
                        state_next = mrrpm_pkg::FSM_PRE;
                    else
                        state_next = mrrpm_pkg::FSM_EXEC;
                end
            end
            mrrpm_pkg::FSM_PRE:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = mrrpm_pkg::FSM_EXEC;
            end
            mrrpm_pkg::FSM_EXEC:
            begin
                state_next = mrrpm_pkg::FSM_POST;
            end
            mrrpm_pkg::FSM_POST:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = mrrpm_pkg::FSM_DONE;
            end
            mrrpm_pkg::FSM_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = mrrpm_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = mrrpm_pkg::FSM_IDLE;
            end
        endcase
    end

    assign accept = item_valid && !item_stall;

    // scan pass counter
    always_comb
    begin
        if (((state_reg == mrrpm_pkg::FSM_PRE) || (state_reg == mrrpm_pkg::FSM_POST)) &&
            (cnt_reg != CNT_LAST))
            cnt_next = cnt_reg + CW'(1);
        else
            cnt_next = '0;
    end

    // control and producer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mrrpm_pkg::FSM_IDLE;
            cnt_reg          <= '0;
            fresh_reg        <= 1'b0;
            prod_off_reg     <= 16'd0;
            prod_on_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg.wr || (state_reg == mrrpm_pkg::FSM_EXEC))
                fresh_reg <= 1'b0;
            else if (out_load)
                fresh_reg <= 1'b1;
            if (cfg.rewind)
                prod_off_reg <= 16'd0;
            else if (state_reg == mrrpm_pkg::FSM_EXEC)
                prod_off_reg <= prod_off_next;
            if (state_reg == mrrpm_pkg::FSM_EXEC)
                prod_on_reg <= prod_on_next;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // item capture, pending result and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            slot_reg <= slot;
            len_reg  <= length;
            minl_reg <= min_length;
        end
        if (state_reg == mrrpm_pkg::FSM_EXEC)
        begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_addr_reg   <= res_addr_next;
            res_count_reg  <= res_count_next;
        end
        if (out_load)
        begin
            status_reg      <= res_status_reg;
            slot_out_reg    <= res_slot_reg;
            address_reg     <= res_addr_reg;
            count_reg       <= res_count_reg;
            put_space_reg   <= space_now;
            min_get_reg     <= chain[SLOTS].any ? chain[SLOTS].lo : 16'd0;
            max_get_reg     <= hi_sum;
            producer_on_reg <= prod_on_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign slot_out     = slot_out_reg;
    assign address      = address_reg;
    assign count        = count_reg;
    assign put_space    = put_space_reg;
    assign min_get      = min_get_reg;
    assign max_get      = max_get_reg;
    assign producer_on  = producer_on_reg;

endmodule

// ===== src/mrrpm_cell.sv =====
// one consumer slot: offset, attach bit and one step of the backlog scan
module mrrpm_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mrrpm_pkg::cell_cmd_t cmd,
    input  logic [16:0]         size,
    input  logic [3:0]          count,
    input  logic [15:0]         prod,
    input  mrrpm_pkg::scan_t    scan_in,
    output mrrpm_pkg::scan_t    scan_out,
    output logic [15:0]         offset,
    output logic                active
);

    logic [15:0]      offset_reg, offset_next;
    logic             active_reg, active_next;
    mrrpm_pkg::scan_t scan_reg, scan_next;
    logic             hit;
    logic             en;
    logic [15:0]      blog;

    assign hit = (cmd.slot == 3'(IDX));
    assign en  = active_reg && (4'(IDX) < count);

    // slot update from the broadcast command
    always_comb
    begin
        offset_next = offset_reg;
        active_next = active_reg;
        case (cmd.op)
            mrrpm_pkg::CELL_ATTACH:
            begin
                if (hit)
                begin
                    active_next = 1'b1;
                    offset_next = cmd.offset;
                end
            end
            mrrpm_pkg::CELL_RELEASE:
            begin
                if (hit)
                    active_next = 1'b0;
            end
            mrrpm_pkg::CELL_LOAD:
            begin
                if (hit)
                    offset_next = cmd.offset;
            end
            mrrpm_pkg::CELL_REWIND:
            begin
                offset_next = 16'd0;
            end
            default:
            begin
                offset_next = offset_reg;
            end
        endcase
    end

    // fold this slot's backlog into the running summary
    always_comb
    begin
        blog      = mrrpm_pkg::backlog(prod, offset_reg, size);
        scan_next = scan_in;
        if (en)
        begin
            scan_next.any = 1'b1;
            if (blog > scan_in.hi)
                scan_next.hi = blog;
            if (blog < scan_in.lo)
                scan_next.lo = blog;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 16'd0;
            active_reg <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            active_reg <= active_next;
        end
    end

    // summary stage, payload only
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;
    assign offset   = offset_reg;
    assign active   = active_reg;

endmodule

// ===== src/mrrpm_cfg.sv =====
// configuration registers behind the apb port, with clamped values in use
module mrrpm_cfg #(
    parameter int SIZE_CAP = 65536,
    parameter int SLOTS    = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mrrpm_pkg::cfg_t   cfg
);

    localparam logic [16:0] CAP17 = 17'(SIZE_CAP);
    localparam logic [3:0]  CAP4  = 4'(SLOTS);

    logic [16:0] size_raw_reg;
    logic [16:0] size_eff_reg;
    logic [31:0] base_reg;
    logic [3:0]  cnt_raw_reg;
    logic [3:0]  cnt_eff_reg;
    logic        wr;
    logic [1:0]  idx;
    logic [16:0] size_clamp;
    logic [3:0]  cnt_clamp;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[3:2];

    // clamp written values to the range the ring supports
    always_comb
    begin
        if (pwdata[16:0] < 17'd2)
            size_clamp = 17'd2;
        else if (pwdata[16:0] > CAP17)
            size_clamp = CAP17;
        else
            size_clamp = pwdata[16:0];

        if (pwdata[3:0] < 4'd1)
            cnt_clamp = 4'd1;
        else if (pwdata[3:0] > CAP4)
            cnt_clamp = CAP4;
        else
            cnt_clamp = pwdata[3:0];
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_raw_reg <= 17'(mrrpm_pkg::SIZE_LIMIT);
            size_eff_reg <= CAP17;
            base_reg     <= 32'd0;
            cnt_raw_reg  <= 4'(mrrpm_pkg::SLOT_LIMIT);
            cnt_eff_reg  <= CAP4;
        end
        else if (wr)
        begin
            unique case (idx)
                mrrpm_pkg::REG_RING_SIZE:
                begin
                    size_raw_reg <= pwdata[16:0];
                    size_eff_reg <= size_clamp;
                end
                mrrpm_pkg::REG_RING_BASE:
                begin
                    base_reg <= pwdata;
                end
                mrrpm_pkg::REG_CONS_CNT:
                begin
                    cnt_raw_reg <= pwdata[3:0];
                    cnt_eff_reg <= cnt_clamp;
                end
                default:
                begin
                    base_reg <= base_reg;
                end
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (idx)
            mrrpm_pkg::REG_RING_SIZE: prdata = {15'd0, size_raw_reg};
            mrrpm_pkg::REG_RING_BASE: prdata = base_reg;
            mrrpm_pkg::REG_CONS_CNT:  prdata = {28'd0, cnt_raw_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.size   = size_eff_reg;
    assign cfg.base   = base_reg;
    assign cfg.count  = cnt_eff_reg;
    assign cfg.rewind = wr && (idx == mrrpm_pkg::REG_RING_SIZE);
    assign cfg.wr     = wr;

endmodule

// ===== src/mrrpm_checker.sv =====
// port-level checks for the ring pointer manager, bound to the top level
module mrrpm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [2:0]  status,
    input logic [2:0]  slot_out,
    input logic [31:0] address,
    input logic [16:0] count,
    input logic [15:0] min_get,
    input logic [15:0] max_get
);

    // a stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(status) && $stable(address) && $stable(count))
        else $error("stalled result changed");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item taken while the previous one is in progress");

    // a failed action moves nothing
    a_fail_no_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != mrrpm_pkg::ST_OK) |->
            (count == 17'd0) && (address == 32'd0) && (slot_out == 3'd0))
        else $error("failed action reports a transfer");

    // smallest backlog never above the largest
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> min_get <= max_get)
        else $error("min_get above max_get");

endmodule

bind multi_reader_ring_pointer_manager mrrpm_checker u_mrrpm_checker (.*);
